[rtl/apsp_pkg.sv]
// Package for the all-pairs shortest path engine: payload structs, command codes,
// sizes, the front-to-back queue entry and the back-end states. No dependencies.
`default_nettype none
package apsp_pkg;
  localparam int unsigned NODES_DEF    = 64;
  localparam int unsigned CULTURES_DEF = 64;
  localparam int unsigned DIST_W_DEF   = 24;
  localparam int unsigned NODE_W       = 6;
  localparam int unsigned CULT_W       = 6;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned OUT_DIST_W   = 24;
  localparam int unsigned COUNT_W      = 7;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_CULTURE = 3'd1,
    CMD_REJECT  = 3'd2,
    CMD_ROAD    = 3'd3,
    CMD_SOLVE   = 3'd4,
    CMD_QUERY   = 3'd5,
    CMD_NOP6    = 3'd6,
    CMD_NOP7    = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [NODE_W-1:0]   node_from;
    logic [NODE_W-1:0]   node_to;
    logic [WEIGHT_W-1:0] road_weight;
    logic [CULT_W-1:0]   culture_first;
    logic [CULT_W-1:0]   culture_second;
    logic                rejects;
  } in_item_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] distance;
    logic                  unreachable;
    logic                  solve_done;
  } out_item_t;

  // Classified work for the back end.
  typedef struct packed {
    cmd_t                op;
    logic [NODE_W-1:0]   node_from;
    logic [NODE_W-1:0]   node_to;
    logic [WEIGHT_W-1:0] road_weight;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_RD1, ST_CHK1, ST_WR1, ST_RD2, ST_CHK2, ST_WR2,
    ST_SRD, ST_SWAIT, ST_SCMP, ST_QRD, ST_QWAIT, ST_EMIT
  } back_st_t;
endpackage
`default_nettype wire

[rtl/all_pairs_shortest_path_engine_top.sv]
// All-pairs shortest path engine.
// Channels: in_ (valid/stall) carries command items; out_ (valid/stall) carries
// query answers and solve acknowledgements; cfg_ (valid/ready) writes node_count.
// Items enter a two-entry queue after the front end, one item a cycle while it has
// room. Culture and rejection writes finish at acceptance but wait until the queue
// is empty and the back end idle, so earlier roads see the tables they were sent with.
// The back end runs one job at a time from the queue: a road reads and may lower
// both directed entries, a query reads its entry, a clear writes one matrix entry
// a cycle through the single RAM write port, and a solve relaxes one entry at a
// time, paced by the one read port of the distance RAM.
// Reset clears control and queue and returns node_count to 64; it then starts a
// pass that zeroes all 4096 rejection matrix entries, with in_stall high throughout.
// The distance matrix is undefined until a clear command.
// A stalled result holds in the output register; the back end waits when its next
// result is ready, and the queue fills, after which in_stall rises.
// Depends on apsp_pkg and the apsp_ modules.
`default_nettype none
module all_pairs_shortest_path_engine_top import apsp_pkg::*; #(
  parameter int unsigned MAX_NODES    = NODES_DEF,
  parameter int unsigned MAX_CULTURES = CULTURES_DEF,
  parameter int unsigned DIST_WIDTH   = DIST_W_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);
  logic [COUNT_W-1:0] count_r;
  logic push, full, nemp, pop, bab, bba, bidle;
  job_t pd, hd;
  logic [NODE_W-1:0] la, lb;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= COUNT_RESET;
    else if (cfg_valid) count_r <= cfg_data;
  end

  apsp_front #(.MAX_NODES(MAX_NODES), .MAX_CULTURES(MAX_CULTURES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_push(push), .q_data(pd), .q_full(full), .q_not_empty(nemp), .back_idle(bidle),
    .look_a(la), .look_b(lb), .blocked_ab(bab), .blocked_ba(bba)
  );
  apsp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(pd), .full(full),
    .not_empty(nemp), .pop(pop), .head(hd)
  );
  apsp_back #(.MAX_NODES(MAX_NODES), .DIST_WIDTH(DIST_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .node_count(count_r), .q_valid(nemp), .q_head(hd),
    .q_pop(pop), .idle(bidle), .look_a(la), .look_b(lb), .blocked_ab(bab),
    .blocked_ba(bba), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire

[rtl/apsp_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module apsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/apsp_front.sv]
// Front end: accepts items, keeps node cultures and the rejection matrix in RAM,
// drops no-ops and pushes road, clear, solve and query jobs to the queue. Uses apsp_pkg, apsp_ram.
`default_nettype none
module apsp_front import apsp_pkg::*; #(
  parameter int unsigned MAX_NODES    = NODES_DEF,
  parameter int unsigned MAX_CULTURES = CULTURES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_push,
  output job_t          q_data,
  input  wire logic     q_full,
  input  wire logic     q_not_empty,
  input  wire logic     back_idle,
  // road admission lookups for the back end
  input  wire logic [NODE_W-1:0] look_a,
  input  wire logic [NODE_W-1:0] look_b,
  output logic          blocked_ab,
  output logic          blocked_ba
);
  localparam int unsigned NA = $clog2(MAX_NODES);
  localparam int unsigned RD = MAX_CULTURES * MAX_CULTURES;
  localparam int unsigned RA = $clog2(RD);

  logic              accept, order_hold, cult_wr, rej_wr;
  cmd_t              cmd;
  logic              clearing_r, clearing_nxt;
  logic [RA-1:0]     clr_r, clr_nxt;
  logic [CULT_W-1:0] cult_a, cult_b;
  logic              rej_ab, rej_ba, a_ok, b_ok;
  logic              rej_we, rej_wd;
  logic [RA-1:0]     rej_wa, rej_ra_ab, rej_ra_ba;

  assign cmd = cmd_t'(in_data.command);
  // hold table writes until every earlier road has been carried out
  assign order_hold = (cmd inside {CMD_CULTURE, CMD_REJECT}) && (q_not_empty || !back_idle);
  assign in_stall   = clearing_r || q_full || order_hold;
  assign accept     = in_valid && !in_stall;

  assign cult_wr = accept && cmd == CMD_CULTURE && 32'(in_data.node_from) < MAX_NODES;
  assign rej_wr  = accept && cmd == CMD_REJECT && 32'(in_data.culture_first) < MAX_CULTURES
                   && 32'(in_data.culture_second) < MAX_CULTURES;

  // two copies so both ends of a road are looked up in the same cycle
  apsp_ram #(.WIDTH(CULT_W), .DEPTH(MAX_NODES)) u_cult_a (
    .clk(clk), .wr_en(cult_wr), .wr_addr(NA'(in_data.node_from)),
    .wr_data(in_data.culture_first), .rd_addr(NA'(look_a)), .rd_data(cult_a)
  );
  apsp_ram #(.WIDTH(CULT_W), .DEPTH(MAX_NODES)) u_cult_b (
    .clk(clk), .wr_en(cult_wr), .wr_addr(NA'(in_data.node_from)),
    .wr_data(in_data.culture_first), .rd_addr(NA'(look_b)), .rd_data(cult_b)
  );

  // sweep the rejection matrix to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_r      <= clr_nxt;
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_nxt      = clr_r;
    if (clearing_r) begin
      clr_nxt = clr_r + 1'b1;
      if (clr_r == RA'(RD - 1)) clearing_nxt = 1'b0;
    end
  end

  assign rej_we    = clearing_r || rej_wr;
  assign rej_wa    = clearing_r ? clr_r
                     : RA'(32'(in_data.culture_first) * MAX_CULTURES
                           + 32'(in_data.culture_second));
  assign rej_wd    = !clearing_r && in_data.rejects;
  // a->b blocked if b's culture rejects a's
  assign rej_ra_ab = RA'(32'(cult_b) * MAX_CULTURES + 32'(cult_a));
  assign rej_ra_ba = RA'(32'(cult_a) * MAX_CULTURES + 32'(cult_b));

  apsp_ram #(.WIDTH(1), .DEPTH(RD)) u_rej_ab (
    .clk(clk), .wr_en(rej_we), .wr_addr(rej_wa), .wr_data(rej_wd),
    .rd_addr(rej_ra_ab), .rd_data(rej_ab)
  );
  apsp_ram #(.WIDTH(1), .DEPTH(RD)) u_rej_ba (
    .clk(clk), .wr_en(rej_we), .wr_addr(rej_wa), .wr_data(rej_wd),
    .rd_addr(rej_ra_ba), .rd_data(rej_ba)
  );

  assign a_ok       = 32'(cult_a) < MAX_CULTURES;
  assign b_ok       = 32'(cult_b) < MAX_CULTURES;
  assign blocked_ab = rej_ab && a_ok && b_ok;
  assign blocked_ba = rej_ba && a_ok && b_ok;

  always_comb begin
    q_data.op          = cmd;
    q_data.node_from   = in_data.node_from;
    q_data.node_to     = in_data.node_to;
    q_data.road_weight = in_data.road_weight;
    case (cmd)
      CMD_CLEAR, CMD_SOLVE, CMD_QUERY: q_push = accept;
      CMD_ROAD: q_push = accept && 32'(in_data.node_from) < MAX_NODES
                         && 32'(in_data.node_to) < MAX_NODES;
      default: q_push = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

[rtl/apsp_queue.sv]
// Two-entry job queue between front and back ends. Uses apsp_pkg.
`default_nettype none
module apsp_queue import apsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  output logic      not_empty,
  input  wire logic pop,
  output job_t      head
);
  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count corrupt");
`endif
endmodule
`default_nettype wire

[rtl/apsp_back.sv]
// Back end: distance matrix in RAM; clear sweep, road update, Floyd-Warshall
// relaxation one entry at a time, query read, result register. Uses apsp_pkg, apsp_ram.
`default_nettype none
module apsp_back import apsp_pkg::*; #(
  parameter int unsigned MAX_NODES  = NODES_DEF,
  parameter int unsigned DIST_WIDTH = DIST_W_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COUNT_W-1:0] node_count,
  input  wire logic               q_valid,
  input  wire job_t               q_head,
  output logic                    q_pop,
  output logic                    idle,
  output logic [NODE_W-1:0]       look_a,
  output logic [NODE_W-1:0]       look_b,
  input  wire logic               blocked_ab,
  input  wire logic               blocked_ba,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data
);
  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned AW = 2 * NW;
  localparam logic [DIST_WIDTH-1:0] INF = '1;

  back_st_t st_r, st_nxt;
  logic [NW-1:0] k_r, i_r, j_r, k_nxt, i_nxt, j_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [NW:0]   n_lim;
  logic [DIST_WIDTH-1:0] dik_r, dik_nxt;
  out_item_t res_r, res_nxt;
  logic      ov_r, ov_nxt;

  logic                  we;
  logic [AW-1:0]         wa, ra;
  logic [DIST_WIDTH-1:0] wd, rd;

  apsp_ram #(.WIDTH(DIST_WIDTH), .DEPTH(1 << AW)) u_dist (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
  );

  assign look_a = q_head.node_from;
  assign look_b = q_head.node_to;
  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign idle      = st_r == ST_IDLE;

  always_comb begin
    if (32'(node_count) > MAX_NODES) n_lim = (NW+1)'(MAX_NODES);
    else n_lim = (NW+1)'(node_count);
  end

  function automatic logic [DIST_WIDTH-1:0] sat(input logic [DIST_WIDTH-1:0] a,
                                                input logic [DIST_WIDTH-1:0] b);
    logic [DIST_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == INF || b == INF || s >= {1'b0, INF}) return INF;
    return s[DIST_WIDTH-1:0];
  endfunction

  logic [NW-1:0] fa, ta;
  logic [DIST_WIDTH-1:0] wext, sum;
  assign fa   = NW'(q_head.node_from);
  assign ta   = NW'(q_head.node_to);
  assign wext = DIST_WIDTH'(q_head.road_weight);
  assign sum  = sat(dik_r, rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end
  always_ff @(posedge clk) begin
    k_r <= k_nxt; i_r <= i_nxt; j_r <= j_nxt; clr_r <= clr_nxt;
    dik_r <= dik_nxt; res_r <= res_nxt;
  end

  always_comb begin
    st_nxt = st_r; k_nxt = k_r; i_nxt = i_r; j_nxt = j_r; clr_nxt = clr_r;
    dik_nxt = dik_r; res_nxt = res_r; ov_nxt = ov_r && out_stall;
    q_pop = 1'b0; we = 1'b0; wa = '0; wd = '0; ra = '0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            CMD_CLEAR: begin clr_nxt = '0; st_nxt = ST_CLEAR; end
            CMD_ROAD:  st_nxt = ST_RD1;
            CMD_SOLVE: begin
              k_nxt = '0; i_nxt = '0; j_nxt = '0;
              st_nxt = (n_lim == '0) ? ST_EMIT : ST_SRD;
            end
            CMD_QUERY: st_nxt = ST_QRD;
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_CLEAR: begin
        we = 1'b1; wa = clr_r;
        wd = (clr_r[AW-1:NW] == clr_r[NW-1:0]) ? '0 : INF;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin q_pop = 1'b1; st_nxt = ST_IDLE; end
      end
      // hold the read address while the culture lookups settle
      ST_RD1: begin ra = {fa, ta}; st_nxt = ST_CHK1; end
      ST_CHK1: begin ra = {fa, ta}; st_nxt = ST_WR1; end
      ST_WR1: begin
        if (!blocked_ab && wext < rd) begin we = 1'b1; wa = {fa, ta}; wd = wext; end
        st_nxt = ST_RD2;
      end
      ST_RD2: begin ra = {ta, fa}; st_nxt = ST_CHK2; end
      ST_CHK2: begin ra = {ta, fa}; st_nxt = ST_WR2; end
      ST_WR2: begin
        if (!blocked_ba && wext < rd) begin we = 1'b1; wa = {ta, fa}; wd = wext; end
        q_pop = 1'b1; st_nxt = ST_IDLE;
      end
      // relaxation: read d[i][k], then d[k][j], then d[i][j]
      ST_SRD: begin ra = {i_r, k_r}; st_nxt = ST_SWAIT; end
      ST_SWAIT: begin dik_nxt = rd; ra = {k_r, j_r}; st_nxt = ST_SCMP; end
      ST_SCMP: begin
        // rd holds d[k][j]; sum is registered next cycle via dik
        dik_nxt = sum; ra = {i_r, j_r}; st_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (dik_r < rd) begin we = 1'b1; wa = {i_r, j_r}; wd = dik_r; end
        st_nxt = ST_SRD;
        if ((NW+1)'(j_r) + 1'b1 == n_lim) begin
          j_nxt = '0;
          if ((NW+1)'(i_r) + 1'b1 == n_lim) begin
            i_nxt = '0;
            if ((NW+1)'(k_r) + 1'b1 == n_lim) st_nxt = ST_EMIT;
            else k_nxt = k_r + 1'b1;
          end else i_nxt = i_r + 1'b1;
        end else j_nxt = j_r + 1'b1;
      end
      ST_QRD: begin ra = {fa, ta}; st_nxt = ST_EMIT; end
      ST_EMIT: begin
        // keep the query entry on the read port while the result register is held
        ra = {fa, ta};
        if (!ov_r || !out_stall) begin
          if (q_head.op == CMD_QUERY) begin
            res_nxt.solve_done = 1'b0;
            if (32'(q_head.node_from) >= MAX_NODES || 32'(q_head.node_to) >= MAX_NODES
                || rd == INF) begin
              res_nxt.distance = '0; res_nxt.unreachable = 1'b1;
            end else begin
              res_nxt.distance = OUT_DIST_W'(rd); res_nxt.unreachable = 1'b0;
            end
          end else begin
            res_nxt = '{distance: '0, unreachable: 1'b0, solve_done: 1'b1};
          end
          ov_nxt = 1'b1; q_pop = 1'b1; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop without job");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(res_r)) else $error("result lost");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> !we) else $error("stray write");
`endif
endmodule
`default_nettype wire
